// ===== design/hhe_pkg.sv =====
// Package for the HTTP Host header extractor.
// Holds the parse phase type, the queue entry type and the pattern table.
// No dependencies.
package hhe_pkg;

   localparam int HOST_MAX_DEFAULT = 256;
   localparam int PAT_LEN          = 7;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_AW         = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CHAR_CR  = 8'h0d;
   localparam logic [7:0] CHAR_LF  = 8'h0a;
   localparam logic [7:0] CHAR_SP  = 8'h20;
   localparam logic [7:0] CHAR_TAB = 8'h09;

   typedef enum logic [1:0] {
      PH_SEARCH = 2'd0,
      PH_SKIP   = 2'd1,
      PH_VALUE  = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   // One classified byte handed from the front to the back.
   typedef struct packed {
      logic       take;
      logic [7:0] data;
      logic       last;
   } entry_type;

   // Queue status seen by the input handshake (full) and the back (empty).
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [7:0] pattern_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = CHAR_CR;
         3'd1:    b = CHAR_LF;
         3'd2:    b = 8'h68;
         3'd3:    b = 8'h6f;
         3'd4:    b = 8'h73;
         3'd5:    b = 8'h74;
         3'd6:    b = 8'h3a;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] lower_byte(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5a) begin
         r = c + 8'd32;
      end
      return r;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SP) || (c == CHAR_TAB);
   endfunction

   function automatic logic is_eol(input logic [7:0] c);
      return (c == CHAR_CR) || (c == CHAR_LF);
   endfunction

endpackage

// ===== design/hhe_front.sv =====
// Front end of the Host header extractor: pattern search and phase tracking.
// Marks each accepted byte as a value byte or not. Depends on hhe_pkg.
module hhe_front
   import hhe_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  logic [7:0] in_byte,
   input  logic      in_last,
   output entry_type entry
);

   phase_type  phase_ff, phase_in;
   logic [2:0] match_ff, match_in;
   logic [2:0] match_cur;
   logic [7:0] low_c;

   assign low_c     = lower_byte(in_byte);
   assign match_cur = (match_ff >= 3'(PAT_LEN)) ? 3'd0 : match_ff;

   // Next state.
   always_comb begin
      phase_in = phase_ff;
      match_in = match_ff;
      unique case (phase_ff)
         PH_SEARCH: begin
            if (low_c == pattern_byte(match_cur)) begin
               if (match_cur == 3'(PAT_LEN - 1)) begin
                  match_in = 3'd0;
                  phase_in = PH_SKIP;
               end else begin
                  match_in = match_cur + 3'd1;
               end
            end else begin
               match_in = (in_byte == CHAR_CR) ? 3'd1 : 3'd0;
            end
         end
         PH_SKIP: begin
            if (is_eol(in_byte)) begin
               phase_in = PH_DONE;
            end else if (!is_blank(in_byte)) begin
               phase_in = PH_VALUE;
            end
         end
         PH_VALUE: begin
            if (is_eol(in_byte)) begin
               phase_in = PH_DONE;
            end
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_SEARCH;
         end
      endcase
      if (in_last) begin
         phase_in = PH_SEARCH;
         match_in = 3'd0;
      end
   end

   // Outputs.
   always_comb begin
      entry.take = 1'b0;
      entry.data = in_byte;
      entry.last = in_last;
      unique case (phase_ff)
         PH_SKIP:  entry.take = !is_eol(in_byte) && !is_blank(in_byte);
         PH_VALUE: entry.take = !is_eol(in_byte);
         default:  entry.take = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEARCH;
         match_ff <= 3'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         match_ff <= match_in;
      end
   end

endmodule

// ===== design/hhe_queue.sv =====
// Short queue between the front and the back of the Host header extractor.
// Flip-flop storage with read and write pointers. Depends on hhe_pkg.
module hhe_queue
   import hhe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head,
   output queue_status_type status
);

   entry_type             slots_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]     count_ff;

   assign status.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== design/hhe_back.sv =====
// Back end of the Host header extractor: value counting, trimming, overflow
// and the registered result beat. Depends on hhe_pkg.
module hhe_back
   import hhe_pkg::*;
#(
   parameter int HOST_MAX = HOST_MAX_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_ready,
   input  entry_type  head,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic       rsp_tlast,
   output logic [0:0] rsp_tuser
);

   localparam int CW = $clog2(HOST_MAX + 1);

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] trim_ff, trim_in;
   logic          ovf_ff, ovf_in;
   logic          emit;
   logic [CW+7:0] count_wide;
   logic [CW+8:0] trim_wide;

   logic          out_valid_ff;
   logic          out_user_ff, out_user_in;
   logic [31:0]   out_data_ff, out_data_in;
   logic          out_last_ff;

   assign pop = head_ready && (!out_valid_ff || rsp_tready);

   always_comb begin
      count_in = count_ff;
      trim_in  = trim_ff;
      ovf_in   = ovf_ff;
      emit     = 1'b0;
      if (head.take) begin
         if (count_ff >= CW'(HOST_MAX)) begin
            ovf_in = 1'b1;
         end else begin
            emit     = 1'b1;
            count_in = count_ff + 1'b1;
            if (!is_blank(head.data)) begin
               trim_in = count_ff + 1'b1;
            end
         end
      end
   end

   assign count_wide = {8'd0, count_ff};
   assign trim_wide  = {9'd0, trim_in};

   always_comb begin
      out_data_in = '0;
      out_user_in = emit;
      if (emit) begin
         out_data_in[7:0]  = head.data;
         out_data_in[15:8] = count_wide[7:0];
      end
      if (head.last) begin
         out_data_in[16]    = (trim_in != '0);
         out_data_in[25:17] = trim_wide[8:0];
         out_data_in[26]    = ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         trim_ff      <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            // The end of a payload returns the counters to their idle values.
            if (head.last) begin
               count_ff <= '0;
               trim_ff  <= '0;
               ovf_ff   <= 1'b0;
            end else begin
               count_ff <= count_in;
               trim_ff  <= trim_in;
               ovf_ff   <= ovf_in;
            end
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_data_ff <= out_data_in;
         out_user_ff <= out_user_in;
         out_last_ff <= head.last;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_data_ff;
   assign rsp_tlast    = out_last_ff;
   assign rsp_tuser[0] = out_user_ff;

endmodule

// ===== design/http_host_header_extract_core.sv =====
// Top level of the HTTP Host header extractor.
// Instantiates hhe_front, hhe_queue and hhe_back; depends on hhe_pkg.
//
// The block takes one payload byte per beat and returns exactly one result beat
// per input beat, in order. It sustains one byte per clock cycle while the
// output is not stalled; a byte's result passes through the four-entry queue
// and then the output register. The front searches for a case-insensitive CR
// LF "host:" and classifies bytes; the back counts value bytes, trims trailing
// blanks, cuts the value at HOST_MAX bytes and reports found, length and
// truncation on the beat with tlast. State returns to idle after every last byte.
module http_host_header_extract_core
   import hhe_pkg::*;
#(
   parameter int HOST_MAX = HOST_MAX_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] payload_byte
   input  logic        req_tlast,   // payload_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] value_byte, [15:8] value_index, [16] host_found,
   // [25:17] host_length, [26] host_truncated, [31:27] zero
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast,   // end_of_payload
   output logic [0:0]  rsp_tuser    // [0] value_valid
);

   entry_type        front_entry;
   entry_type        head;
   queue_status_type status;
   logic             accept;
   logic             pop;

   assign req_tready = !status.full;
   assign accept     = req_tvalid && req_tready;

   hhe_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_tdata),
      .in_last (req_tlast),
      .entry   (front_entry)
   );

   hhe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (front_entry),
      .pop        (pop),
      .head       (head),
      .status     (status)
   );

   hhe_back #(
      .HOST_MAX (HOST_MAX)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_ready (!status.empty),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTHESIS
   // Summary fields are only nonzero on the last beat of a payload.
   a_summary_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_tdata[26:16] == 11'd0))
      else $error("summary fields set on a beat that is not last");

   // A found host always comes with a nonzero trimmed length.
   a_found_matches_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[16] == (rsp_tdata[25:17] != 9'd0)))
      else $error("host_found disagrees with host_length");

   // Beats without a value byte carry zero byte and index.
   a_idle_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[15:0] == 16'd0))
      else $error("value fields set without value_valid");
`endif

endmodule
